// ===== design/ws2p_pkg.sv =====
// shared constants and helper functions for the wav sample to pcm16 decoder
package ws2p_pkg;

  localparam int unsigned InWidth = 64;
  localparam int unsigned OutWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_FORMAT_TAG = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_SAMPLE_BITS = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_VBITS = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_CONTAINER = 2'd3;

  // codec tags
  localparam logic [15:0] TAG_PCM = 16'd1;
  localparam logic [15:0] TAG_FLOAT = 16'd3;
  localparam logic [15:0] TAG_ALAW = 16'd6;
  localparam logic [15:0] TAG_MULAW = 16'd7;

  // g.711 a-law expansion of one code byte
  function automatic logic signed [15:0] alaw_expand(input logic [7:0] code);
    logic [7:0] v;
    logic [2:0] seg;
    logic [15:0] t;
    begin
      v = code ^ 8'h55;
      seg = v[6:4];
      if (seg == 3'd0) begin
        t = {8'd0, v[3:0], 4'd0} + 16'd8;
      end else begin
        t = ({8'd0, v[3:0], 4'd0} + 16'h0108) << (seg - 3'd1);
      end
      alaw_expand = v[7] ? $signed(t) : -$signed(t);
    end
  endfunction

  // g.711 mu-law expansion of one code byte
  function automatic logic signed [15:0] mulaw_expand(input logic [7:0] code);
    logic [7:0] v;
    logic [15:0] mag;
    begin
      v = ~code;
      mag = (({9'd0, v[3:0], 3'd0} + 16'h0084) << v[6:4]) - 16'h0084;
      mulaw_expand = v[7] ? -$signed(mag) : $signed(mag);
    end
  endfunction

endpackage

// ===== design/ws2p_stream_if.sv =====
// valid/ready stream channel with a generic payload
interface ws2p_stream_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/wav_sample_to_pcm16.sv =====
// Top level: decodes one WAV sample container per request into signed pcm16.
// Usage:
//   in   : sink channel, data = sample_bytes (64 bits, byte 0 in bits 7:0)
//   out  : source channel, data = pcm_sample (16 bits, two's complement)
//   cfg_*: write port; index 0 format_tag, 1 sample_bits, 2 valid bit count,
//          3 container_bytes; other indexes are ignored
// Each request is decoded by one pass of logic between the input register
// and the output register: it is registered in the input stage on
// acceptance and moves to the output stage once that stage has room.
// Throughput is one request per cycle while results are taken, set by the
// two-stage register pipe; in_ready follows the output stage, so a held
// result stalls input only when both stages are full.
// Reset (synchronous, rst_n low) empties both stages and sets the registers
// to tag 1, 16 sample bits, 16 valid bits, 2-byte container.
// When the receiver stalls, results hold on out_data and the pipe fills.
// Configuration is written while idle only: a user rule, not enforced.
module wav_sample_to_pcm16
  import ws2p_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  ws2p_stream_if.sink             in_if,
  ws2p_stream_if.source           out_if,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  logic [15:0] format_tag_r;
  logic [6:0]  sample_bits_r;
  logic [6:0]  vbits_r;
  logic [3:0]  container_r;

  logic        s1_valid_r;
  logic [63:0] s1_data_r;
  logic        s2_valid_r;
  logic [15:0] s2_data_r;
  logic        s2_load;
  logic        s1_load;

  logic signed [15:0] pcm_nxt;
  logic signed [15:0] int_pcm;
  logic signed [15:0] flt_pcm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_tag_r <= 16'd1;
      sample_bits_r <= 7'd16;
      vbits_r <= 7'd16;
      container_r <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT_TAG: format_tag_r <= cfg_data;
        REG_SAMPLE_BITS: sample_bits_r <= cfg_data[6:0];
        REG_VBITS: vbits_r <= cfg_data[6:0];
        REG_CONTAINER: container_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // pipe control
  assign s2_load = s1_valid_r && (!s2_valid_r || out_if.ready);
  assign s1_load = !s1_valid_r || s2_load;
  assign in_if.ready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load) s1_valid_r <= in_if.valid;
      if (s2_load) s2_valid_r <= 1'b1;
      else if (out_if.ready) s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_if.valid) s1_data_r <= in_if.data;
    if (s2_load) s2_data_r <= pcm_nxt;
  end

  // integer pcm path
  logic [5:0]  cbits;
  logic [6:0]  vb;
  logic signed [31:0] x;
  logic signed [31:0] xs;
  logic signed [31:0] xa;
  logic [5:0]  sh1;
  always_comb begin
    int_pcm = 16'sd0;
    cbits = (container_r >= 4'd4) ? 6'd32 : {container_r[2:0], 3'd0};
    vb = (vbits_r != 7'd0) ? vbits_r : sample_bits_r;
    if (vb > {1'b0, cbits}) vb = {1'b0, cbits};
    if (vb == 7'd0) vb = {1'b0, cbits};
    case (container_r)
      4'd2: x = {{16{s1_data_r[15]}}, s1_data_r[15:0]};
      4'd3: x = {{8{s1_data_r[23]}}, s1_data_r[23:0]};
      default: x = s1_data_r[31:0];
    endcase
    sh1 = cbits - vb[5:0];
    xs = x >>> sh1;
    xa = xs;
    if (vb > 7'd16) xa = xs >>> (vb[5:0] - 6'd16);
    else if (vb < 7'd16) xa = xs <<< (6'd16 - vb[5:0]);
    if (sample_bits_r == 7'd8) begin
      if (container_r >= 4'd1) int_pcm = $signed({s1_data_r[7:0] ^ 8'h80, 8'd0});
    end else if ((sample_bits_r == 7'd16 || sample_bits_r == 7'd24 ||
                  sample_bits_r == 7'd32) && container_r >= 4'd2) begin
      if (xa > 32'sd32767) int_pcm = 16'sd32767;
      else if (xa < -32'sd32768) int_pcm = -16'sd32768;
      else int_pcm = xa[15:0];
    end
  end

  ws2p_float_dec u_float (
    .raw            (s1_data_r),
    .sample_bits    (sample_bits_r),
    .container_bytes(container_r),
    .pcm            (flt_pcm)
  );

  // format select
  always_comb begin
    pcm_nxt = 16'sd0;
    case (format_tag_r)
      TAG_PCM: pcm_nxt = int_pcm;
      TAG_FLOAT: pcm_nxt = flt_pcm;
      TAG_ALAW: if (container_r >= 4'd1) pcm_nxt = alaw_expand(s1_data_r[7:0]);
      TAG_MULAW: if (container_r >= 4'd1) pcm_nxt = mulaw_expand(s1_data_r[7:0]);
      default: pcm_nxt = 16'sd0;
    endcase
  end

  assign out_if.valid = s2_valid_r;
  assign out_if.data = s2_data_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> s1_valid_r)
    else $error("accepted request lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("stalled with empty output");
`endif

endmodule

// ===== design/ws2p_float_dec.sv =====
// float32/float64 container to pcm16 conversion
module ws2p_float_dec
  import ws2p_pkg::*;
(
  input  logic [63:0]        raw,
  input  logic [6:0]         sample_bits,
  input  logic [3:0]         container_bytes,
  output logic signed [15:0] pcm
);

  logic        use32;
  logic        use64;
  logic        sgn;
  logic        nonfin;
  logic        ge_one;
  logic signed [12:0] e;      // unbiased exponent
  logic [23:0] man;           // significand with hidden bit, rounded to 24 bits
  logic [28:0] m64;
  logic        rbit;
  logic        sticky;
  logic [24:0] mr;
  logic [39:0] prod;          // man * 32767
  logic        rup;
  logic [39:0] prod_rnd;      // product rounded to a 24-bit significand
  logic [39:0] shv;
  logic [15:0] mag;
  logic [5:0]  shamt;
  logic [39:0] rnd;

  assign use32 = (sample_bits == 7'd32) && (container_bytes >= 4'd4);
  assign use64 = (sample_bits == 7'd64) && (container_bytes >= 4'd8);

  // unpack and round the source to a 24-bit significand
  always_comb begin
    sgn = 1'b0;
    nonfin = 1'b0;
    e = '0;
    man = '0;
    m64 = '0;
    rbit = 1'b0;
    sticky = 1'b0;
    mr = '0;
    if (use32) begin
      sgn = raw[31];
      nonfin = (raw[30:23] == 8'hFF);
      e = $signed({5'd0, raw[30:23]}) - 13'sd127;
      man = {(raw[30:23] != 8'd0), raw[22:0]};
    end else begin
      sgn = raw[63];
      nonfin = (raw[62:52] == 11'h7FF);
      e = $signed({2'd0, raw[62:52]}) - 13'sd1023;
      // values below 2^-126 scale to zero anyway
      m64 = {1'b1, raw[51:24]};
      rbit = raw[28];
      sticky = |raw[27:0];
      mr = {1'b0, m64[28:5]} + {24'd0, rbit & (sticky | raw[29])};
      if (mr[24]) begin
        man = mr[24:1];
        e = e + 13'sd1;
      end else begin
        man = mr[23:0];
      end
      // rounds to infinity in single precision
      if (e >= 13'sd128) nonfin = 1'b1;
      if (raw[62:52] == 11'd0) man = '0;
    end
  end

  assign ge_one = (e >= 13'sd0);

  // scale by 32767 in single precision and truncate
  assign prod = {16'd0, man} * 40'd32767;

  // round the product to nearest even at 24 significant bits
  always_comb begin
    if (prod[38]) begin
      rup = prod[14] & ((|prod[13:0]) | prod[15]);
      prod_rnd = {prod[39:15] + {24'd0, rup}, 15'd0};
    end else begin
      rup = prod[13] & ((|prod[12:0]) | prod[14]);
      prod_rnd = {prod[39:14] + {25'd0, rup}, 14'd0};
    end
  end

  assign shamt = (e < -13'sd40) ? 6'd63 : 6'(-(e - 13'sd23));
  assign shv = prod_rnd >> shamt;
  assign rnd = shv;

  always_comb begin
    mag = 16'd0;
    if (ge_one) mag = 16'd32767;
    else if (e >= -13'sd23) mag = rnd[15:0];
    else mag = 16'd0;
    if (!(use32 || use64) || nonfin) pcm = 16'sd0;
    else pcm = sgn ? -$signed(mag) : $signed(mag);
  end

endmodule
